FILE: rtl/core/npq_pkg.sv
// Shared constants, item type and distance helper for the nearest palette colour quantiser.
package npq_pkg;

	// Default number of palette entries, one cell each.
	localparam int NPQ_ENTRIES = 256;

	// Field widths fixed by the interface.
	localparam int CHAN_W  = 8;
	localparam int INDEX_W = 8;
	localparam int COLOR_W = 3 * CHAN_W;

	// A squared RGB distance is at most 3 * 255 * 255, which fits in 18 bits.
	localparam int DIST_W = 18;

	// Running best distance before any entry is seen: larger than any real distance.
	localparam logic [DIST_W-1:0] DIST_NONE = '1;

	// Configuration port.
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam logic REG_ALPHA_THRESHOLD = 1'b0;
	localparam logic [CHAN_W-1:0] ALPHA_THRESHOLD_RESET = 8'd128;

	// Command codes of the input channel.
	localparam logic CMD_WRITE    = 1'b0;
	localparam logic CMD_QUANTIZE = 1'b1;

	// Payload that travels down the chain of cells with each item.
	typedef struct packed {
		logic              cmd;
		logic [INDEX_W-1:0] entry_index;
		logic [CHAN_W-1:0]  red;
		logic [CHAN_W-1:0]  green;
		logic [CHAN_W-1:0]  blue;
		logic               transparent;
		logic [INDEX_W-1:0] best_index;
		logic [DIST_W-1:0]  lead_gap;
	} npq_item_t;

	// Square of the absolute difference of two channel values.
	function automatic logic [2*CHAN_W-1:0] sq_diff(input logic [CHAN_W-1:0] a,
			input logic [CHAN_W-1:0] b);
		logic [CHAN_W-1:0] d;
		d = (a > b) ? (a - b) : (b - a);
		return (2*CHAN_W)'(d) * (2*CHAN_W)'(d);
	endfunction

endpackage

FILE: rtl/core/nearest_palette_color_quantizer.sv
// Each item passes one cell per palette entry, then the output register, from input transfer to result.
// Throughput: one item per cycle unless the chain holds; writes and searches travel the same chain, so order holds.
// The whole chain holds only while a finished result waits at the output and is stalled.
// Palette writes give no result; transparent pixels still pass the chain and give index 0.
// Reset clears the item valid bits, the output valid and sets alpha_threshold to 128.
// Palette colours are not reset and are undefined until written.
module nearest_palette_color_quantizer import npq_pkg::*; #(
	parameter int PALETTE_ENTRIES = NPQ_ENTRIES
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// Input channel.
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  cmd,
	input  logic [INDEX_W-1:0]    entry_index,
	input  logic [CHAN_W-1:0]     red,
	input  logic [CHAN_W-1:0]     green,
	input  logic [CHAN_W-1:0]     blue,
	input  logic [CHAN_W-1:0]     alpha,
	// Output channel.
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [INDEX_W-1:0]    color_index,
	// Configuration port.
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	logic [CHAN_W-1:0]  alpha_threshold_q;
	logic               valid_c [PALETTE_ENTRIES+1];
	npq_item_t          item_c  [PALETTE_ENTRIES+1];
	logic               advance;
	logic               tail_result;
	logic               out_valid_q;
	logic [INDEX_W-1:0] color_index_q;

	// Configuration register.
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_threshold_q <= ALPHA_THRESHOLD_RESET;
		end else if (psel && penable && pwrite && (paddr[2] == REG_ALPHA_THRESHOLD)) begin
			alpha_threshold_q <= pwdata[CHAN_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_ALPHA_THRESHOLD)
		? {{(APB_DATA_W-CHAN_W){1'b0}}, alpha_threshold_q} : '0;

	// The chain moves unless a result at its end cannot leave.
	assign tail_result = valid_c[PALETTE_ENTRIES]
		&& (item_c[PALETTE_ENTRIES].cmd == CMD_QUANTIZE);
	assign advance  = !(tail_result && out_valid_q && out_stall);
	assign in_stall = !advance;

	// Chain entry: transparency is settled here and the search starts empty.
	assign valid_c[0]            = in_valid;
	assign item_c[0].cmd         = cmd;
	assign item_c[0].entry_index = entry_index;
	assign item_c[0].red         = red;
	assign item_c[0].green       = green;
	assign item_c[0].blue        = blue;
	assign item_c[0].transparent = (alpha < alpha_threshold_q);
	assign item_c[0].best_index  = '0;
	assign item_c[0].lead_gap    = DIST_NONE;

	// One cell per palette entry.
	for (genvar k = 0; k < PALETTE_ENTRIES; k++) begin : g_cell
		npq_cell #(
			.CELL_INDEX(k)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.advance (advance),
			.valid_i (valid_c[k]),
			.item_i  (item_c[k]),
			.valid_o (valid_c[k+1]),
			.item_o  (item_c[k+1])
		);
	end

	// Output register: a search result lands here; writes leave the chain silently.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && tail_result) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && tail_result) begin
			color_index_q <= item_c[PALETTE_ENTRIES].transparent
				? '0 : item_c[PALETTE_ENTRIES].best_index;
		end
	end

	assign out_valid   = out_valid_q;
	assign color_index = color_index_q;

endmodule

FILE: rtl/core/npq_cell.sv
// One cell of the palette search chain: holds one palette colour and refines the running best.
module npq_cell import npq_pkg::*; #(
	parameter int CELL_INDEX = 0
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      advance,
	input  logic      valid_i,
	input  npq_item_t item_i,
	output logic      valid_o,
	output npq_item_t item_o
);

	logic [COLOR_W-1:0] palette_q;
	logic               valid_q;
	npq_item_t          item_q;
	logic [DIST_W-1:0]  gap_sq;
	logic               hit_write;
	logic               better;
	npq_item_t          item_next;

	// A write for this entry is captured as it passes, so order against searches holds.
	assign hit_write = valid_i && (item_i.cmd == CMD_WRITE)
		&& (item_i.entry_index == INDEX_W'(CELL_INDEX));

	// Distance from the pixel to the colour held here.
	assign gap_sq = DIST_W'(sq_diff(item_i.red,   palette_q[3*CHAN_W-1:2*CHAN_W]))
		+ DIST_W'(sq_diff(item_i.green, palette_q[2*CHAN_W-1:CHAN_W]))
		+ DIST_W'(sq_diff(item_i.blue,  palette_q[CHAN_W-1:0]));

	// Strictly smaller only, so the lowest index wins a tie.
	assign better = (item_i.cmd == CMD_QUANTIZE) && !item_i.transparent
		&& (gap_sq < item_i.lead_gap);

	always_comb begin
		item_next = item_i;
		if (better) begin
			item_next.lead_gap   = gap_sq;
			item_next.best_index = INDEX_W'(CELL_INDEX);
		end
	end

	// Palette colour, undefined until written.
	always_ff @(posedge clk) begin
		if (advance && hit_write) begin
			palette_q <= {item_i.red, item_i.green, item_i.blue};
		end
	end

	// Hand the item on to the next cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			item_q <= item_next;
		end
	end

	assign valid_o = valid_q;
	assign item_o  = item_q;

endmodule

FILE: rtl/core/npq_checker.sv
// Port-level checks for the nearest palette colour quantiser, bound to the top level.
module npq_checker import npq_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_stall,
	input logic                  out_valid,
	input logic                  out_stall,
	input logic [INDEX_W-1:0]    color_index,
	input logic                  psel,
	input logic                  pwrite,
	input logic [APB_DATA_W-1:0] prdata
);

	// A stalled result stays offered and unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(color_index))
		else $error("stalled result changed or was dropped");

	// The input side only holds back while a result waits and is stalled.
	a_in_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a waiting result");

	// No result is offered while reset is applied.
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("result offered during reset");

	// Register reads carry only the threshold byte.
	a_read_width: assert property (@(posedge clk) disable iff (!arst_n)
		psel && !pwrite |-> prdata[APB_DATA_W-1:CHAN_W] == '0)
		else $error("register read returned stray upper bits");

endmodule

bind nearest_palette_color_quantizer npq_checker u_npq_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.color_index (color_index),
	.psel        (psel),
	.pwrite      (pwrite),
	.prdata      (prdata)
);
